// File: sv/gwdm_pkg.sv
// Shared types and constants of the grid wavefront distance map.
package gwdm_pkg;

  // Distance code width and its special values.
  localparam int DIST_W = 11;
  localparam logic [DIST_W-1:0] DIST_UNREACH = 11'h7FF;
  localparam logic [DIST_W-1:0] DIST_SAT     = 11'h7FE;
  localparam logic [DIST_W-1:0] DIST_ZERO    = 11'h000;

  // Item modes.
  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_COMPUTE = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;

  // Neighbour visiting order during relaxation.
  localparam logic [1:0] NB_LEFT  = 2'd0;
  localparam logic [1:0] NB_DOWN  = 2'd1;
  localparam logic [1:0] NB_RIGHT = 2'd2;
  localparam logic [1:0] NB_UP    = 2'd3;

  // Input beat.
  typedef struct packed {
    logic [1:0] mode;
    logic [4:0] cell_row;
    logic [4:0] cell_col;
    logic       wall;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              is_completion;
  } out_beat_t;

  // Control strobes towards the cell store.
  typedef struct packed {
    logic rd_en;
    logic wall_we;
    logic wall_wd;
    logic dist_we;
  } cell_ctl_t;

  // Control strobes towards the wave queue.
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } queue_ctl_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_RD_WAIT,
    ST_CLEAR,
    ST_SEED,
    ST_POP,
    ST_POP_WAIT,
    ST_NB_RD,
    ST_NB_CHK,
    ST_DONE
  } gwdm_state_t;

endpackage

// File: sv/gwdm_cell_store.sv
// Wall flag and distance memories of the grid, one synchronous read port each.
module gwdm_cell_store #(
  parameter  int DEPTH = 1024,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  gwdm_pkg::cell_ctl_t           ctl,
  input  logic [AW-1:0]                 rd_addr,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [gwdm_pkg::DIST_W-1:0]   dist_wd,
  output logic                          wall_rd_r,
  output logic [gwdm_pkg::DIST_W-1:0]   dist_rd_r
);
  import gwdm_pkg::*;

  logic              wall_mem [DEPTH];
  logic [DIST_W-1:0] dist_mem [DEPTH];

  // Wall memory: written by load items and the reset clearing pass.
  always_ff @(posedge clk) begin
    if (ctl.wall_we) begin
      wall_mem[wr_addr] <= ctl.wall_wd;
    end
    if (ctl.rd_en) begin
      wall_rd_r <= wall_mem[rd_addr];
    end
  end

  // Distance memory: read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (ctl.dist_we) begin
      dist_mem[wr_addr] <= dist_wd;
    end
    if (ctl.rd_en) begin
      dist_rd_r <= dist_mem[rd_addr];
    end
  end

endmodule

// File: sv/gwdm_wave_queue.sv
// Wavefront queue: cells waiting to have their neighbours relaxed.
module gwdm_wave_queue #(
  parameter  int DEPTH = 1024,
  parameter  int QW    = 21,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gwdm_pkg::queue_ctl_t   ctl,
  input  logic [QW-1:0]          push_data,
  output logic [QW-1:0]          pop_data_r,
  output logic                   empty,
  output logic                   full
);
  import gwdm_pkg::*;

  localparam logic [AW:0] FILL_MAX = (AW+1)'(DEPTH);

  logic [QW-1:0] mem [DEPTH];
  logic [AW:0]   head_r, head_nxt;
  logic [AW:0]   tail_r, tail_nxt;

  // Each cell enters at most once per compute, so the pointers never wrap.
  assign empty = (head_r == tail_r);
  assign full  = (tail_r == FILL_MAX);

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (ctl.clear) begin
      head_nxt = '0;
      tail_nxt = '0;
    end else begin
      if (ctl.pop) begin
        head_nxt = head_r + 1'b1;
      end
      if (ctl.push) begin
        tail_nxt = tail_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  // Queue storage with registered read data.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_r[AW-1:0]] <= push_data;
    end
    if (ctl.pop) begin
      pop_data_r <= mem[head_r[AW-1:0]];
    end
  end

endmodule

// File: sv/gwdm_ctrl.sv
// Sequencer: item decode, clearing passes and breadth-first relaxation.
module gwdm_ctrl #(
  parameter  int GRID_W = 32,
  parameter  int GRID_H = 32,
  localparam int CELLS  = GRID_W * GRID_H,
  localparam int AW     = $clog2(CELLS),
  localparam int RW     = $clog2(GRID_H),
  localparam int CW     = $clog2(GRID_W),
  localparam int QW     = RW + CW + gwdm_pkg::DIST_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gwdm_pkg::in_beat_t            in_beat,
  output logic                          res_valid,
  input  logic                          res_ready,
  output gwdm_pkg::out_beat_t           res_beat,
  output gwdm_pkg::cell_ctl_t           cell_ctl,
  output logic [AW-1:0]                 cell_rd_addr,
  output logic [AW-1:0]                 cell_wr_addr,
  output logic [gwdm_pkg::DIST_W-1:0]   cell_dist_wd,
  input  logic                          wall_rd_r,
  input  logic [gwdm_pkg::DIST_W-1:0]   dist_rd_r,
  output gwdm_pkg::queue_ctl_t          q_ctl,
  output logic [QW-1:0]                 q_push_data,
  input  logic [QW-1:0]                 q_pop_data,
  input  logic                          q_empty,
  input  logic                          q_full
);
  import gwdm_pkg::*;

  localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(GRID_H - 1);
  localparam logic [CW-1:0] COL_LAST  = CW'(GRID_W - 1);

  gwdm_state_t       state_r, state_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic              src_hit_r, src_hit_nxt;
  logic [RW-1:0]     src_row_r, src_row_nxt;
  logic [CW-1:0]     src_col_r, src_col_nxt;
  logic              rd_hit_r, rd_hit_nxt;
  logic [RW-1:0]     cur_row_r, cur_row_nxt;
  logic [CW-1:0]     cur_col_r, cur_col_nxt;
  logic [DIST_W-1:0] cur_nd_r, cur_nd_nxt;
  logic [1:0]        nb_r, nb_nxt;
  logic [RW-1:0]     nb_row_r, nb_row_nxt;
  logic [CW-1:0]     nb_col_r, nb_col_nxt;
  logic [AW-1:0]     nb_addr_r, nb_addr_nxt;

  logic              in_hit;
  logic [RW-1:0]     in_row;
  logic [CW-1:0]     in_col;
  logic [AW-1:0]     in_addr;
  logic              nb_ok;
  logic [RW-1:0]     nb_row;
  logic [CW-1:0]     nb_col;
  logic [RW-1:0]     pop_row;
  logic [CW-1:0]     pop_col;
  logic [DIST_W-1:0] pop_dist;

  // Row-major linear address of a cell.
  function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
    addr_of = AW'(r) * AW'(GRID_W) + AW'(c);
  endfunction

  // Decode of the addressed cell of the incoming beat.
  assign in_hit  = (32'(in_beat.cell_row) < GRID_H) && (32'(in_beat.cell_col) < GRID_W);
  assign in_row  = RW'(in_beat.cell_row);
  assign in_col  = CW'(in_beat.cell_col);
  assign in_addr = addr_of(in_row, in_col);

  assign {pop_row, pop_col, pop_dist} = q_pop_data;

  // Coordinates and bounds check of the neighbour under consideration.
  always_comb begin
    nb_row = cur_row_r;
    nb_col = cur_col_r;
    nb_ok  = 1'b0;
    case (nb_r)
      NB_LEFT: begin
        nb_ok  = (cur_col_r != '0);
        nb_col = cur_col_r - 1'b1;
      end
      NB_DOWN: begin
        nb_ok  = (cur_row_r != ROW_LAST);
        nb_row = cur_row_r + 1'b1;
      end
      NB_RIGHT: begin
        nb_ok  = (cur_col_r != COL_LAST);
        nb_col = cur_col_r + 1'b1;
      end
      NB_UP: begin
        nb_ok  = (cur_row_r != '0);
        nb_row = cur_row_r - 1'b1;
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  // Next state and outputs.
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    src_hit_nxt  = src_hit_r;
    src_row_nxt  = src_row_r;
    src_col_nxt  = src_col_r;
    rd_hit_nxt   = rd_hit_r;
    cur_row_nxt  = cur_row_r;
    cur_col_nxt  = cur_col_r;
    cur_nd_nxt   = cur_nd_r;
    nb_nxt       = nb_r;
    nb_row_nxt   = nb_row_r;
    nb_col_nxt   = nb_col_r;
    nb_addr_nxt  = nb_addr_r;
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    res_beat     = '{distance: DIST_ZERO, is_completion: 1'b0};
    cell_ctl     = '0;
    cell_rd_addr = in_addr;
    cell_wr_addr = cnt_r;
    cell_dist_wd = DIST_UNREACH;
    q_ctl        = '0;
    q_push_data  = {nb_row_r, nb_col_r, cur_nd_r};

    case (state_r)
      // Reset clearing pass: every cell open and unreachable.
      ST_INIT: begin
        cell_ctl.wall_we = 1'b1;
        cell_ctl.wall_wd = 1'b0;
        cell_ctl.dist_we = 1'b1;
        cnt_nxt          = cnt_r + 1'b1;
        if (cnt_r == CELL_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_beat.mode)
            MODE_WRITE: begin
              cell_ctl.wall_we = in_hit;
              cell_ctl.wall_wd = in_beat.wall;
              cell_wr_addr     = in_addr;
            end
            MODE_COMPUTE: begin
              src_hit_nxt = in_hit;
              src_row_nxt = in_row;
              src_col_nxt = in_col;
              q_ctl.clear = 1'b1;
              cnt_nxt     = '0;
              state_nxt   = ST_CLEAR;
            end
            MODE_READ: begin
              cell_ctl.rd_en = 1'b1;
              rd_hit_nxt     = in_hit;
              state_nxt      = ST_RD_WAIT;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      // Read data is held by the store until the result is taken.
      ST_RD_WAIT: begin
        res_valid              = 1'b1;
        res_beat.distance      = rd_hit_r ? dist_rd_r : DIST_UNREACH;
        res_beat.is_completion = 1'b0;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      // Compute clearing pass over the distance memory.
      ST_CLEAR: begin
        cell_ctl.dist_we = 1'b1;
        cnt_nxt          = cnt_r + 1'b1;
        if (cnt_r == CELL_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_SEED;
        end
      end

      // An in-grid source gets distance zero and starts the wavefront; an off-grid source ends the compute.
      ST_SEED: begin
        if (src_hit_r) begin
          cell_ctl.dist_we = 1'b1;
          cell_wr_addr     = addr_of(src_row_r, src_col_r);
          cell_dist_wd     = DIST_ZERO;
          q_ctl.push       = 1'b1;
          q_push_data      = {src_row_r, src_col_r, DIST_ZERO};
          state_nxt        = ST_POP;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_POP: begin
        if (q_empty) begin
          state_nxt = ST_DONE;
        end else begin
          q_ctl.pop = 1'b1;
          state_nxt = ST_POP_WAIT;
        end
      end

      // Neighbours of the popped cell are offered one step more, saturating.
      ST_POP_WAIT: begin
        cur_row_nxt = pop_row;
        cur_col_nxt = pop_col;
        cur_nd_nxt  = (pop_dist >= DIST_SAT) ? DIST_SAT : pop_dist + 1'b1;
        nb_nxt      = NB_LEFT;
        state_nxt   = ST_NB_RD;
      end

      ST_NB_RD: begin
        if (nb_ok) begin
          cell_ctl.rd_en = 1'b1;
          cell_rd_addr   = addr_of(nb_row, nb_col);
          nb_addr_nxt    = addr_of(nb_row, nb_col);
          nb_row_nxt     = nb_row;
          nb_col_nxt     = nb_col;
          state_nxt      = ST_NB_CHK;
        end else if (nb_r == NB_UP) begin
          state_nxt = ST_POP;
        end else begin
          nb_nxt = nb_r + 1'b1;
        end
      end

      // Enter an open neighbour that improves. The write lands before the
      // next read is issued, so no forwarding is needed.
      ST_NB_CHK: begin
        if (!wall_rd_r && (dist_rd_r > cur_nd_r)) begin
          cell_ctl.dist_we = 1'b1;
          cell_wr_addr     = nb_addr_r;
          cell_dist_wd     = cur_nd_r;
          q_ctl.push       = !q_full;
        end
        if (nb_r == NB_UP) begin
          state_nxt = ST_POP;
        end else begin
          nb_nxt    = nb_r + 1'b1;
          state_nxt = ST_NB_RD;
        end
      end

      ST_DONE: begin
        res_valid              = 1'b1;
        res_beat.distance      = DIST_ZERO;
        res_beat.is_completion = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    src_hit_r <= src_hit_nxt;
    src_row_r <= src_row_nxt;
    src_col_r <= src_col_nxt;
    rd_hit_r  <= rd_hit_nxt;
    cur_row_r <= cur_row_nxt;
    cur_col_r <= cur_col_nxt;
    cur_nd_r  <= cur_nd_nxt;
    nb_r      <= nb_nxt;
    nb_row_r  <= nb_row_nxt;
    nb_col_r  <= nb_col_nxt;
    nb_addr_r <= nb_addr_nxt;
  end

  // A neighbour check always follows the read that it consumes.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_NB_CHK |-> $past(state_r) == ST_NB_RD && $past(cell_ctl.rd_en))
    else $error("neighbour check without a preceding read");

  // A compute item starts the clearing pass with an empty queue.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_beat.mode == MODE_COMPUTE |=> state_r == ST_CLEAR && q_empty)
    else $error("compute did not start from a cleared queue");

  // The queue is only popped when it holds a cell.
  assert property (@(posedge clk) disable iff (!rst_n)
    q_ctl.pop |-> !q_empty)
    else $error("pop from an empty wave queue");

  // The reset clearing pass happens once.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_INIT |=> state_r != ST_INIT)
    else $error("reset clearing pass re-entered");

endmodule

// File: sv/grid_wavefront_distance_map.sv
// Top level of the grid wavefront distance map.
//
//  Channel  Ports                           Direction  Beat contents
//  input    in_valid, in_ready, in_beat     in         mode, cell_row, cell_col, wall
//  result   out_valid, out_ready, out_beat  out        distance, is_completion
//
// A write beat is written in the state that takes it; a read beat reads the cell store and its
// held data is then offered to the output register. A compute beat clears the distance of all
// GRID_W*GRID_H cells, seeds an in-grid source, then pops each reached cell and reads and checks
// each in-grid neighbour in turn through the one read address of the cell store, skipping those
// off the grid; a final pop finds the queue empty before the completion result is offered.
// After reset a clearing pass over all GRID_W*GRID_H cells runs before the first beat is taken.
// The output register lets a new beat be taken while a result waits on out_ready.
module grid_wavefront_distance_map #(
  parameter int GRID_W = 32,
  parameter int GRID_H = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gwdm_pkg::in_beat_t    in_beat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gwdm_pkg::out_beat_t   out_beat
);
  import gwdm_pkg::*;

  localparam int CELLS = GRID_W * GRID_H;
  localparam int AW    = $clog2(CELLS);
  localparam int QW    = $clog2(GRID_H) + $clog2(GRID_W) + DIST_W;

  logic              res_valid;
  logic              res_ready;
  out_beat_t         res_beat;
  cell_ctl_t         cell_ctl;
  logic [AW-1:0]     cell_rd_addr;
  logic [AW-1:0]     cell_wr_addr;
  logic [DIST_W-1:0] cell_dist_wd;
  logic              wall_rd_r;
  logic [DIST_W-1:0] dist_rd_r;
  queue_ctl_t        q_ctl;
  logic [QW-1:0]     q_push_data;
  logic [QW-1:0]     q_pop_data;
  logic              q_empty;
  logic              q_full;
  logic              out_valid_r;
  out_beat_t         out_beat_r;

  gwdm_ctrl #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_beat      (in_beat),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_beat     (res_beat),
    .cell_ctl     (cell_ctl),
    .cell_rd_addr (cell_rd_addr),
    .cell_wr_addr (cell_wr_addr),
    .cell_dist_wd (cell_dist_wd),
    .wall_rd_r    (wall_rd_r),
    .dist_rd_r    (dist_rd_r),
    .q_ctl        (q_ctl),
    .q_push_data  (q_push_data),
    .q_pop_data   (q_pop_data),
    .q_empty      (q_empty),
    .q_full       (q_full)
  );

  gwdm_cell_store #(
    .DEPTH (CELLS)
  ) u_cell_store (
    .clk       (clk),
    .ctl       (cell_ctl),
    .rd_addr   (cell_rd_addr),
    .wr_addr   (cell_wr_addr),
    .dist_wd   (cell_dist_wd),
    .wall_rd_r (wall_rd_r),
    .dist_rd_r (dist_rd_r)
  );

  gwdm_wave_queue #(
    .DEPTH (CELLS),
    .QW    (QW)
  ) u_wave_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (q_ctl),
    .push_data  (q_push_data),
    .pop_data_r (q_pop_data),
    .empty      (q_empty),
    .full       (q_full)
  );

  // Output register between the sequencer and the result channel.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_beat_r <= res_beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

// File: dv/tb_top.sv
// Self-checking testbench of the grid wavefront distance map.
`timescale 1ns / 100ps

module tb_top;
  import gwdm_pkg::*;

  localparam int GRID_W      = 32;
  localparam int GRID_H      = 32;
  localparam int CELL_COUNT  = GRID_W * GRID_H;
  localparam int CYCLE_LIMIT = 12_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int BEAT_GOAL   = 140;
  localparam int QUIET_FROM  = 120;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_beat;

  // Shadow copy of the cell store and the results still to come.
  logic              wall_shadow [CELL_COUNT];
  logic [DIST_W-1:0] dist_shadow [CELL_COUNT];
  out_beat_t         awaited_results [$];

  int fail_count;
  int beats_sent;
  int cycle_count;
  int stall_left;
  bit quiet;

  grid_wavefront_distance_map #(
    .GRID_W(GRID_W),
    .GRID_H(GRID_H)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_beat  (in_beat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_beat (out_beat)
  );

  // Free-running clock, 12 ns period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Breadth-first flood from the source; walls are never entered but the
  // source itself may sit on a wall.
  function automatic void flood_distances(input logic [4:0] row, input logic [4:0] col);
    int unsigned       wave [$];
    int unsigned       cur;
    int unsigned       r;
    int unsigned       c;
    int unsigned       nb;
    bit                ok;
    logic [DIST_W-1:0] nd;
    for (int i = 0; i < CELL_COUNT; i++) begin
      dist_shadow[i] = DIST_UNREACH;
    end
    if (row >= GRID_H || col >= GRID_W) begin
      return;
    end
    cur = row * GRID_W + col;
    dist_shadow[cur] = DIST_ZERO;
    wave.push_back(cur);
    while (wave.size() > 0) begin
      cur = wave.pop_front();
      r = cur / GRID_W;
      c = cur % GRID_W;
      nd = (dist_shadow[cur] >= DIST_SAT) ? DIST_SAT : dist_shadow[cur] + 11'd1;
      for (int k = 0; k < 4; k++) begin
        ok = 1'b0;
        nb = 0;
        case (k)
          0: begin
            ok = (c > 0);
            nb = cur - 1;
          end
          1: begin
            ok = (r + 1 < GRID_H);
            nb = cur + GRID_W;
          end
          2: begin
            ok = (c + 1 < GRID_W);
            nb = cur + 1;
          end
          default: begin
            ok = (r > 0);
            nb = cur - GRID_W;
          end
        endcase
        if (ok && !wall_shadow[nb] && dist_shadow[nb] > nd) begin
          dist_shadow[nb] = nd;
          wave.push_back(nb);
        end
      end
    end
  endfunction

  // Apply one input beat to the shadow grid and queue the result it causes.
  function automatic void grid_shadow_step(input in_beat_t b);
    out_beat_t res;
    bit        inside_grid;
    inside_grid = (b.cell_row < GRID_H) && (b.cell_col < GRID_W);
    case (b.mode)
      MODE_WRITE: begin
        if (inside_grid) begin
          wall_shadow[b.cell_row * GRID_W + b.cell_col] = b.wall;
        end
      end
      MODE_COMPUTE: begin
        flood_distances(b.cell_row, b.cell_col);
        res.distance = DIST_ZERO;
        res.is_completion = 1'b1;
        awaited_results.push_back(res);
      end
      MODE_READ: begin
        res.distance = inside_grid ? dist_shadow[b.cell_row * GRID_W + b.cell_col]
                                   : DIST_UNREACH;
        res.is_completion = 1'b0;
        awaited_results.push_back(res);
      end
      default: begin
      end
    endcase
  endfunction

  // Present one beat and hold it until the block takes it. Valid is left high
  // so that back-to-back beats need no gap.
  task automatic send_beat(input in_beat_t b);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    grid_shadow_step(b);
    if (b.mode != MODE_UNUSED) begin
      beats_sent++;
    end
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_cell(input logic [1:0] mode, input logic [4:0] row,
                           input logic [4:0] col, input logic wall);
    in_beat_t b;
    b.mode     = mode;
    b.cell_row = row;
    b.cell_col = col;
    b.wall     = wall;
    send_beat(b);
  endtask

  // Drop valid and wait until every queued result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Reads straight after reset see the cleared distance store.
  task automatic test_reset_state();
    send_cell(MODE_READ, 5'd0, 5'd0, 1'b0);
    send_cell(MODE_READ, 5'd31, 5'd31, 1'b1);
    send_cell(MODE_UNUSED, 5'd31, 5'd31, 1'b1);
    send_cell(MODE_READ, 5'd31, 5'd0, 1'b0);
  endtask

  // Open grid: floods from opposite corners and reads the far extremes.
  task automatic test_open_grid();
    send_cell(MODE_COMPUTE, 5'd0, 5'd0, 1'b0);
    send_cell(MODE_READ, 5'd31, 5'd31, 1'b0);
    send_cell(MODE_READ, 5'd0, 5'd31, 1'b0);
    send_cell(MODE_READ, 5'd31, 5'd0, 1'b0);
    send_cell(MODE_COMPUTE, 5'd31, 5'd31, 1'b1);
    send_cell(MODE_READ, 5'd0, 5'd0, 1'b0);
  endtask

  // Walls: an enclosed corner, a wall read, a source on a wall, and an
  // unused-mode beat that must not set a wall.
  task automatic test_walls();
    send_cell(MODE_WRITE, 5'd0, 5'd1, 1'b1);
    send_cell(MODE_WRITE, 5'd1, 5'd0, 1'b1);
    send_cell(MODE_COMPUTE, 5'd31, 5'd31, 1'b0);
    send_cell(MODE_READ, 5'd0, 5'd0, 1'b0);
    send_cell(MODE_READ, 5'd0, 5'd1, 1'b0);
    send_cell(MODE_COMPUTE, 5'd0, 5'd1, 1'b0);
    send_cell(MODE_READ, 5'd0, 5'd1, 1'b0);
    send_cell(MODE_READ, 5'd0, 5'd0, 1'b0);
    send_cell(MODE_READ, 5'd1, 5'd1, 1'b0);
    send_cell(MODE_UNUSED, 5'd5, 5'd5, 1'b1);
    send_cell(MODE_WRITE, 5'd0, 5'd1, 1'b0);
    send_cell(MODE_WRITE, 5'd1, 5'd0, 1'b0);
  endtask

  // The sender stops until the block has returned everything, then resumes.
  task automatic test_drain_pause();
    logic [4:0] r;
    logic [4:0] c;
    r = 5'($urandom);
    c = 5'($urandom);
    send_cell(MODE_COMPUTE, r, c, 1'b0);
    send_cell(MODE_READ, 5'd5, 5'd5, 1'b0);
    send_cell(MODE_READ, ~r, ~c, 1'b0);
    drain_results();
    send_cell(MODE_READ, r ^ 5'd1, c, 1'b0);
  endtask

  // One round: scatter walls, maybe some noise, usually recompute, then read
  // cells both near the source and anywhere on the grid.
  task automatic run_maze_round();
    int         n;
    logic [4:0] src_r;
    logic [4:0] src_c;
    n = $urandom_range(2, 12);
    repeat (n) begin
      send_cell(MODE_WRITE, 5'($urandom), 5'($urandom), $urandom_range(0, 2) == 0);
    end
    if ($urandom_range(0, 3) == 0) begin
      send_cell(MODE_UNUSED, 5'($urandom), 5'($urandom), 1'($urandom));
    end
    src_r = 5'($urandom);
    src_c = 5'($urandom);
    if ($urandom_range(0, 5) != 0) begin
      send_cell(MODE_COMPUTE, src_r, src_c, 1'($urandom));
    end
    n = $urandom_range(2, 8);
    repeat (n) begin
      if ($urandom_range(0, 1) == 0) begin
        send_cell(MODE_READ, 5'(src_r + $urandom_range(0, 3)),
                  5'(src_c - $urandom_range(0, 3)), 1'($urandom));
      end else begin
        send_cell(MODE_READ, 5'($urandom), 5'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic test_random_mazes();
    while (beats_sent < QUIET_FROM) run_maze_round();
  endtask

  // Last stretch with no idling on either side.
  task automatic test_quiet_tail();
    quiet <= 1'b1;
    while (beats_sent < BEAT_GOAL) run_maze_round();
  endtask

  // Result channel: out_ready drops in random stall bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin : check_results
    out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result beat: distance %0d is_completion %0b",
               out_beat.distance, out_beat.is_completion);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_beat.distance !== want.distance) begin
          $error("distance: expected %0d, actual %0d", want.distance, out_beat.distance);
          fail_count++;
        end
        if (out_beat.is_completion !== want.is_completion) begin
          $error("is_completion: expected %0b, actual %0b",
                 want.is_completion, out_beat.is_completion);
          fail_count++;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_beat    <= '0;
    out_ready  <= 1'b0;
    stall_left <= 0;
    quiet      <= 1'b0;
    fail_count = 0;
    beats_sent = 0;
    cycle_count <= 0;
    for (int i = 0; i < CELL_COUNT; i++) begin
      wall_shadow[i] = 1'b0;
      dist_shadow[i] = DIST_UNREACH;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_open_grid();
    test_walls();
    test_drain_pause();
    test_random_mazes();
    test_quiet_tail();

    // Let the last beats finish, then give the block time to settle.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
